// ===== rtl/cvtt_pkg.sv =====
// ----------------------------------------------------------------------------
// cvtt_pkg: shared types and constants of the client verdict token table
// Word layouts, table geometry, command and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cvtt_pkg;

  // table geometry and fixed point
  localparam int CLIENTS   = 32;
  localparam int IDX_W     = $clog2(CLIENTS);
  localparam int FRAC_BITS = 8;
  localparam int RATE_W    = 24;
  localparam int TOK_W     = RATE_W + 1;

  // refill arithmetic: rate * elapsed / 1000, elapsed clamped where the cap wins
  localparam int DIVISOR   = 1000;
  localparam int DCLAMP    = 2 * DIVISOR;
  localparam int DCL_W     = $clog2(DCLAMP + 1);
  localparam int PROD_W    = RATE_W + DCL_W;

  // x / 1000 = (x >> 3) / 125, the latter as a multiply by ceil(2^35 / 125),
  // exact for a shifted product of up to 32 bits
  localparam int DIV_PRE     = 3;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_125 = 29'h10624DD3;
  localparam int QUOT_W      = PROD_W - DIV_PRE + RECIP_W;

  localparam logic [TOK_W-1:0] TOKEN_ONE = TOK_W'(1) << FRAC_BITS;

  // commands
  localparam logic [2:0] CMD_UPSERT  = 3'd0;
  localparam logic [2:0] CMD_CONSUME = 3'd1;
  localparam logic [2:0] CMD_DECAY   = 3'd2;
  localparam logic [2:0] CMD_KICK    = 3'd3;
  localparam logic [2:0] CMD_GET     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_DECAY_HOLD   = 3'd0;
  localparam logic [2:0] REG_RENEW_PERIOD = 3'd1;
  localparam logic [2:0] REG_ALLOW_LEVEL  = 3'd2;
  localparam logic [2:0] REG_QUAR_LEVEL   = 3'd3;
  localparam logic [2:0] REG_KICK_LEVEL   = 3'd4;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [4:0]        slot;
    logic [2:0]        level_in;
    logic [31:0]       score_in;
    logic [31:0]       expiry_in;
    logic [RATE_W-1:0] rate_in;
    logic [31:0]       now_ms;
  } in_word_t;

  typedef struct packed {
    logic              allowed;
    logic              found;
    logic [2:0]        level_out;
    logic [31:0]       score_out;
    logic [31:0]       expiry_out;
    logic [RATE_W-1:0] rate_out;
    logic              kick_valid;
    logic [4:0]        kicked_slot;
    logic              last;
  } out_word_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [2:0]        level;
    logic [31:0]       score;
    logic [31:0]       expiry;
    logic [RATE_W-1:0] rate;
    logic [TOK_W-1:0]  tokens;
    logic [31:0]       refill;
    logic [31:0]       decay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/client_verdict_token_table_core.sv =====
// ----------------------------------------------------------------------------
// client_verdict_token_table_core: per-client verdict table and token bucket
// Upsert, get, consume with refill, decay scan and kick scan over one RAM.
// ----------------------------------------------------------------------------
// Upsert, get and unknown commands: one execute state; busy until it ends.
// Consume: execute only when absent; execute, spend when no time has passed;
// else execute, divide, spend, the divide step being the reciprocal multiply
// that divides the refill amount by 1000. Decay and kick scans: one slot per
// cycle over CLIENTS slots, then a closing word. Results are strobed, never stalled.
// Reset (rst_n low, synchronous) clears all valid bits and restores registers.
`default_nettype none

module client_verdict_token_table_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire cvtt_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output cvtt_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [31:0]         cfg_data
);

  import cvtt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SPEND = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t           st_r, st_nxt;
  in_word_t         in_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CLIENTS-1:0] valid_r, valid_nxt;
  entry_t           ent_r, ent_nxt;
  logic             refill_do_r, refill_do_nxt;
  logic [PROD_W-1:0] x_r, x_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // configuration registers
  logic [31:0] decay_hold_r, renew_period_r;
  logic [2:0]  allow_level_r, quar_level_r, kick_level_r;

  // memory port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, rd;

  // helpers
  logic             accept;
  logic [IDX_W-1:0] slot_idx;
  logic             inrange, present;
  logic [31:0]      delta;
  logic [DCL_W-1:0] dcl;
  logic [QUOT_W-1:0] quot;
  logic [TOK_W+1:0] tok_sum;
  logic [TOK_W-1:0] tok_capped;
  logic [TOK_W-1:0] cap;
  logic             dec_hit;
  logic [2:0]       dec_level;

  cvtt_ram #(.WIDTH(ENTRY_W), .DEPTH(CLIENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign busy      = (st_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign slot_idx = IDX_W'(32'(in_r.slot));
  assign inrange  = (32'(in_r.slot) < CLIENTS);
  assign present  = inrange && valid_r[slot_idx];

  // read address: item slot at start (slot 0 for scans), next slot while scanning
  always_comb begin
    if (st_r == ST_SCAN) begin
      ram_raddr = idx_r + IDX_W'(1);
    end else if (in_word.cmd == CMD_KICK || in_word.cmd == CMD_DECAY) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = IDX_W'(32'(in_word.slot));
    end
  end

  // elapsed time, clamped where the cap is reached anyway
  assign delta = in_r.now_ms - rd.refill;
  assign dcl   = (delta >= 32'(DCLAMP)) ? DCL_W'(DCLAMP) : DCL_W'(delta);

  // divide by 1000 as a shift and a reciprocal multiply
  assign quot = QUOT_W'(x_r[PROD_W-1:DIV_PRE]) * QUOT_W'(RECIP_125);

  // refill and cap
  assign cap        = {ent_r.rate, 1'b0};
  assign tok_sum    = (TOK_W+2)'(ent_r.tokens) + (TOK_W+2)'(x_r);
  assign tok_capped = !refill_do_r ? ent_r.tokens :
                      (tok_sum > (TOK_W+2)'(cap)) ? cap : TOK_W'(tok_sum);

  // decay test on the scanned entry
  assign dec_hit   = valid_r[idx_r] && (in_r.now_ms > rd.expiry) &&
                     (in_r.now_ms >= rd.decay) &&
                     ((in_r.now_ms - rd.decay) >= decay_hold_r);
  assign dec_level = (rd.level > allow_level_r) ? rd.level - 3'd1 : rd.level;

  // main sequencer
  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    ent_nxt       = ent_r;
    refill_do_nxt = refill_do_r;
    x_nxt         = x_r;
    out_nxt       = '0;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_idx;
    ram_wdata     = rd;

    case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          st_nxt = (in_word.cmd == CMD_KICK || in_word.cmd == CMD_DECAY) ? ST_SCAN
                                                                        : ST_EXEC;
        end
      end

      ST_EXEC: begin
        st_nxt       = ST_IDLE;
        out_nxt.last = 1'b1;
        case (in_r.cmd)
          CMD_UPSERT: begin
            if (inrange) begin
              ram_we          = 1'b1;
              ram_wdata.level  = in_r.level_in;
              ram_wdata.score  = in_r.score_in;
              ram_wdata.expiry = in_r.expiry_in;
              ram_wdata.rate   = in_r.rate_in;
              if (!valid_r[slot_idx]) begin
                ram_wdata.tokens = {in_r.rate_in, 1'b0};
                ram_wdata.refill = in_r.now_ms;
                ram_wdata.decay  = in_r.now_ms;
              end
              valid_nxt[slot_idx] = 1'b1;
            end
          end
          CMD_GET: begin
            if (present) begin
              out_nxt.found      = 1'b1;
              out_nxt.level_out  = rd.level;
              out_nxt.score_out  = rd.score;
              out_nxt.expiry_out = rd.expiry;
              out_nxt.rate_out   = rd.rate;
            end
          end
          CMD_CONSUME: begin
            if (!present) begin
              out_nxt.allowed = 1'b1;
            end else begin
              // result comes later from the spend step
              out_nxt.last  = 1'b0;
              ent_nxt       = rd;
              refill_do_nxt = (in_r.now_ms > rd.refill);
              x_nxt         = PROD_W'(rd.rate) * PROD_W'(dcl);
              st_nxt        = (in_r.now_ms > rd.refill) ? ST_DIV : ST_SPEND;
            end
          end
          default: ;
        endcase
        out_valid_nxt = out_nxt.last;
      end

      ST_DIV: begin
        // refill amount: product over 1000, fraction dropped
        x_nxt  = PROD_W'(quot[QUOT_W-1:RECIP_SHIFT]);
        st_nxt = ST_SPEND;
      end

      ST_SPEND: begin
        ram_we        = 1'b1;
        ram_wdata     = ent_r;
        out_nxt.found = 1'b1;
        out_nxt.last  = 1'b1;
        out_valid_nxt = 1'b1;
        if (refill_do_r) begin
          ram_wdata.refill = in_r.now_ms;
        end
        if (tok_capped >= TOKEN_ONE) begin
          ram_wdata.tokens = tok_capped - TOKEN_ONE;
          out_nxt.allowed  = 1'b1;
        end else begin
          ram_wdata.tokens = tok_capped;
        end
        st_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        ram_waddr = idx_r;
        if (in_r.cmd == CMD_KICK) begin
          if (valid_r[idx_r] && rd.level == kick_level_r) begin
            ram_we              = 1'b1;
            ram_wdata.level     = quar_level_r;
            out_valid_nxt       = 1'b1;
            out_nxt.kick_valid  = 1'b1;
            out_nxt.kicked_slot = 5'(32'(idx_r));
          end
        end else if (dec_hit) begin
          ram_we           = 1'b1;
          ram_wdata.level  = dec_level;
          ram_wdata.decay  = in_r.now_ms;
          ram_wdata.expiry = in_r.now_ms + renew_period_r;
          if (dec_level == allow_level_r) begin
            valid_nxt[idx_r] = 1'b0;
          end
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (32'(idx_r) == CLIENTS - 1) begin
          st_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        out_nxt.last  = 1'b1;
        out_valid_nxt = 1'b1;
        st_nxt        = ST_IDLE;
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_word;
    end
    idx_r       <= idx_nxt;
    ent_r       <= ent_nxt;
    refill_do_r <= refill_do_nxt;
    x_r         <= x_nxt;
    out_r       <= out_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_hold_r   <= 32'd60000;
      renew_period_r <= 32'd120000;
      allow_level_r  <= 3'd0;
      quar_level_r   <= 3'd2;
      kick_level_r   <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DECAY_HOLD:   decay_hold_r   <= cfg_data;
        REG_RENEW_PERIOD: renew_period_r <= cfg_data;
        REG_ALLOW_LEVEL:  allow_level_r  <= cfg_data[2:0];
        REG_QUAR_LEVEL:   quar_level_r   <= cfg_data[2:0];
        REG_KICK_LEVEL:   kick_level_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cvtt_ram.sv =====
// ----------------------------------------------------------------------------
// cvtt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cvtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
